// File: rtl/sii_pkg.sv
package sii_pkg;

  localparam int SLOTS_DEF    = 4096;
  localparam int POS_BITS_DEF = 32;
  localparam int DEFAULT_RATE = 128000 / 8;
  localparam int YEAR_SECS    = 365 * 24 * 3600;
  localparam int QDEPTH       = 2;

  localparam logic [1:0] REQ_REPORT = 2'd0;
  localparam logic [1:0] REQ_SEEK   = 2'd1;
  localparam logic [1:0] REQ_LENGTH = 2'd2;
  localparam logic [1:0] REQ_NONE   = 2'd3;

  localparam logic CFG_FILE_LENGTH  = 1'b0;
  localparam logic CFG_LENGTH_KNOWN = 1'b1;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [23:0] time_sec;
    logic [31:0] byte_pos;
  } in_item_t;

  typedef struct packed {
    logic [31:0] byte_offset;
    logic        reliable;
    logic        seek_accepted;
    logic [31:0] length_secs;
    logic        arith_fault;
  } out_item_t;

  // classified command from front to back
  typedef struct packed {
    logic [1:0]  op;
    logic [23:0] time_sec;
    logic [31:0] byte_pos;
  } cmd_t;

endpackage

// File: rtl/sii_front.sv
module sii_front (
  input  logic              in_valid,
  output logic              in_ready,
  input  sii_pkg::in_item_t in_data,
  input  logic              q_full,
  output logic              q_push,
  output sii_pkg::cmd_t     q_cmd
);
  // drop unused codes at the door; everything else is queued
  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready && (in_data.req_type != sii_pkg::REQ_NONE);
  assign q_cmd    = '{op: in_data.req_type, time_sec: in_data.time_sec,
                      byte_pos: in_data.byte_pos};
endmodule

// File: rtl/sii_queue.sv
module sii_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  sii_pkg::cmd_t  wdata,
  input  logic           pop,
  output logic           not_empty,
  output sii_pkg::cmd_t  rdata,
  output logic           full
);
  localparam int D = sii_pkg::QDEPTH;
  sii_pkg::cmd_t    mem [D];
  logic [$clog2(D)-1:0] wp, rp;
  logic [$clog2(D):0]   cnt;

  assign not_empty = cnt != '0;
  assign rdata     = mem[rp];
  assign full      = cnt == ($clog2(D)+1)'(D);

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0; rp <= '0; cnt <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (pop)  rp <= rp + 1'b1;
      cnt <= cnt + (($clog2(D)+1)'(push)) - (($clog2(D)+1)'(pop));
    end
  end
  always_ff @(posedge clk) begin
    if (push) mem[wp] <= wdata;
  end
endmodule

// File: rtl/sii_back.sv
module sii_back #(
  parameter int SLOTS    = sii_pkg::SLOTS_DEF,
  parameter int POS_BITS = sii_pkg::POS_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  input  sii_pkg::cmd_t      cmd,
  output logic               cmd_pop,
  input  logic [31:0]        file_length,
  input  logic               length_known,
  output logic               out_valid,
  input  logic               out_ready,
  output sii_pkg::out_item_t out_data
);
  localparam int AW = $clog2(SLOTS);
  localparam int EW = AW + 1;
  localparam logic [63:0] POS_MAX = (POS_BITS >= 64) ? '1 : ((64'd1 << POS_BITS) - 64'd1);
  localparam logic [63:0] SAT_MAX = (POS_MAX < 64'hFFFF_FFFF) ? POS_MAX : 64'hFFFF_FFFF;

  typedef enum logic [4:0] {
    S_IDLE, S_CLR, S_RD_T, S_WAIT_T, S_CHK_T, S_LO_RD, S_LO_WAIT, S_LO_CHK,
    S_HI_RD, S_HI_WAIT, S_HI_CHK, S_LK_RD, S_LK_WAIT, S_LK_CHK,
    S_PREP, S_DIV, S_MUL, S_FIN, S_OUT
  } state_t;

  state_t state;
  logic [31:0] mem [SLOTS];
  logic [31:0] rd;
  logic [AW-1:0] raddr;
  logic          we;
  logic [AW-1:0] waddr;
  logic [31:0]   wdata;

  logic [EW-1:0] extent;
  logic          rel_flag;
  logic [23:0]   last_slot;
  logic [AW-1:0] clr_ptr;

  logic [1:0]  op;
  logic [23:0] t;
  logic [AW:0] idx;
  logic [31:0] lo_t, hi_t;
  logic [31:0] lo_f, hi_f;
  logic        interp;

  // serial divider
  logic [32:0] num, quo, rem_r, den;
  logic [5:0]  dcnt;
  logic        pass2;
  logic [63:0] prod;
  logic [63:0] base;
  logic [31:0] mul_a, mul_b;
  logic        fault;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rd <= mem[raddr];
  end

  logic [33:0] rem_sh;
  assign rem_sh = {rem_r, num[32]};

  assign mul_a = (interp && {8'd0, t} < hi_t) ? ({8'd0, t} - lo_t) : ({8'd0, t} - hi_t);
  assign mul_b = quo[31:0];

  assign cmd_pop = (state == S_IDLE) && cmd_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR; clr_ptr <= '0; extent <= '0; rel_flag <= 1'b1;
      last_slot <= '0; out_valid <= 1'b0; we <= 1'b0;
    end else begin
      we <= 1'b0;
      unique case (state)
        S_CLR: begin
          we <= 1'b1; waddr <= clr_ptr; wdata <= '0;
          clr_ptr <= clr_ptr + 1'b1;
          if (clr_ptr == AW'(SLOTS-1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (cmd_valid) begin
            op <= cmd.op; t <= cmd.time_sec; fault <= 1'b0;
            out_data <= '0;
            if (cmd.op == sii_pkg::REQ_REPORT) begin
              if (rel_flag) begin
                if (cmd.time_sec != last_slot &&
                    {8'd0, cmd.time_sec} < 32'(sii_pkg::YEAR_SECS) &&
                    {8'd0, cmd.time_sec} < 32'(SLOTS)) begin
                  we <= 1'b1; waddr <= cmd.time_sec[AW-1:0]; wdata <= cmd.byte_pos;
                  if ({8'd0, cmd.time_sec} >= 32'(extent)) begin
                    if (cmd.time_sec == '0) extent <= EW'(8);
                    else if ({7'd0, cmd.time_sec, 1'b0} >= 32'(SLOTS)) extent <= EW'(SLOTS);
                    else extent <= EW'({cmd.time_sec, 1'b0});
                  end
                end
                last_slot <= cmd.time_sec;
              end
            end else if (cmd.op == sii_pkg::REQ_SEEK) begin
              if (!length_known) state <= S_OUT;
              else if (cmd.time_sec == '0) begin
                out_data.reliable <= 1'b1; out_data.seek_accepted <= 1'b1;
                rel_flag <= 1'b1; last_slot <= '0; state <= S_OUT;
              end else begin
                out_data.seek_accepted <= 1'b1;
                state <= S_RD_T;
              end
            end else begin
              idx <= (AW+1)'(extent) - 1'b1;
              state <= (extent == '0) ? S_PREP : S_LK_RD;
              hi_t <= '0; hi_f <= '0; lo_t <= '0; lo_f <= '0;
            end
          end
        end
        S_RD_T: begin
          lo_t <= '0; lo_f <= '0; hi_t <= '0; hi_f <= '0;
          if ({8'd0, t} < 32'(extent)) begin
            raddr <= t[AW-1:0]; state <= S_WAIT_T;
          end else begin
            idx <= (AW+1)'(extent) - 1'b1;
            state <= (extent == '0) ? S_PREP : S_LK_RD;
          end
        end
        S_WAIT_T: state <= S_CHK_T;
        S_CHK_T: begin
          if (rd != '0) begin
            out_data.byte_offset <= rd; out_data.reliable <= 1'b1;
            rel_flag <= 1'b1; last_slot <= t; state <= S_OUT;
          end else begin
            idx <= (AW+1)'(t) - 1'b1; state <= S_LO_RD;
          end
        end
        // walk down to the nearest known slot (slot 0 never counts)
        S_LO_RD: begin
          if (idx == '0) begin
            idx <= (AW+1)'(t) + 1'b1; state <= S_HI_RD;
          end else begin
            raddr <= idx[AW-1:0]; state <= S_LO_WAIT;
          end
        end
        S_LO_WAIT: state <= S_LO_CHK;
        S_LO_CHK: begin
          if (rd != '0) begin
            lo_t <= 32'(idx); lo_f <= rd;
            idx <= (AW+1)'(t) + 1'b1; state <= S_HI_RD;
          end else begin
            idx <= idx - 1'b1; state <= S_LO_RD;
          end
        end
        S_HI_RD: begin
          if (idx >= (AW+1)'(extent)) state <= S_PREP;
          else begin raddr <= idx[AW-1:0]; state <= S_HI_WAIT; end
        end
        S_HI_WAIT: state <= S_HI_CHK;
        S_HI_CHK: begin
          if (rd != '0) begin
            hi_t <= 32'(idx); hi_f <= rd; state <= S_PREP;
          end else begin
            idx <= idx + 1'b1; state <= S_HI_RD;
          end
        end
        S_LK_RD: begin
          if (idx == '0) state <= S_PREP;
          else begin raddr <= idx[AW-1:0]; state <= S_LK_WAIT; end
        end
        S_LK_WAIT: state <= S_LK_CHK;
        S_LK_CHK: begin
          if (rd != '0) begin
            hi_t <= 32'(idx); hi_f <= rd; state <= S_PREP;
          end else begin
            idx <= idx - 1'b1; state <= S_LK_RD;
          end
        end
        S_PREP: begin
          rem_r <= '0; quo <= '0; dcnt <= 6'd33; pass2 <= 1'b0;
          if (op == sii_pkg::REQ_SEEK) begin
            interp <= hi_t > lo_t;
            if (hi_t > lo_t) begin
              if (hi_f < lo_f) begin
                fault <= 1'b1; state <= S_FIN;
              end else begin
                num <= {1'b0, hi_f - lo_f}; den <= {1'b0, hi_t - lo_t}; state <= S_DIV;
              end
            end else begin
              quo <= 33'(sii_pkg::DEFAULT_RATE); state <= S_MUL;
            end
          end else begin
            if (hi_f != '0) begin
              num <= {1'b0, hi_f}; den <= {1'b0, hi_t}; state <= S_DIV;
            end else begin
              num <= {1'b0, file_length}; den <= 33'(sii_pkg::DEFAULT_RATE);
              state <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (dcnt == '0) begin
            state <= S_MUL;
            if (op == sii_pkg::REQ_LENGTH && hi_f != '0 && !pass2) begin
              // first pass gave the average; second pass divides remainder
              if (quo == '0 || file_length < hi_f) begin
                fault <= 1'b1; state <= S_FIN;
              end else begin
                num <= {1'b0, file_length - hi_f}; den <= quo; rem_r <= '0;
                quo <= '0; dcnt <= 6'd33; pass2 <= 1'b1; state <= S_DIV;
              end
            end
          end else begin
            num <= {num[31:0], 1'b0};
            if (rem_sh[32:0] >= den) begin
              rem_r <= rem_sh[32:0] - den; quo <= {quo[31:0], 1'b1};
            end else begin
              rem_r <= rem_sh[32:0]; quo <= {quo[31:0], 1'b0};
            end
            dcnt <= dcnt - 1'b1;
          end
        end
        S_MUL: begin
          if (op == sii_pkg::REQ_SEEK) begin
            prod <= 64'(mul_a) * 64'(mul_b);
            if (interp && {8'd0, t} < hi_t) base <= {32'd0, lo_f};
            else base <= {32'd0, hi_f};
          end else begin
            prod <= {32'd0, quo[31:0]};
            base <= (hi_f != '0) ? {32'd0, hi_t} : 64'd0;
          end
          state <= S_FIN;
        end
        S_FIN: begin
          if (op == sii_pkg::REQ_SEEK) begin
            rel_flag <= 1'b0; last_slot <= t;
            out_data.reliable <= 1'b0;
            if (fault) out_data.byte_offset <= '0;
            else if (base + prod > SAT_MAX || base + prod < base)
              out_data.byte_offset <= SAT_MAX[31:0];
            else out_data.byte_offset <= 32'(base + prod);
          end else begin
            if (fault) out_data.length_secs <= '0;
            else if (base + prod > 64'hFFFF_FFFF) out_data.length_secs <= '1;
            else out_data.length_secs <= 32'(base + prod);
          end
          out_data.arith_fault <= fault;
          state <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid) out_valid <= 1'b1;
          else if (out_ready) begin out_valid <= 1'b0; state <= S_IDLE; end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_out_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> state == S_OUT) else $error("result shown outside output state");
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |-> state == S_IDLE) else $error("command taken while busy");
  a_ext_cap: assert property (@(posedge clk) disable iff (rst)
    32'(extent) <= 32'(SLOTS)) else $error("extent beyond table");
endmodule

// File: rtl/seek_index_interpolator.sv
// channel | dir | handshake             | payload
// in      | in  | in_valid / in_ready   | in_data  (req_type, time_sec, byte_pos)
// out     | out | out_valid / out_ready | out_data (byte_offset .. arith_fault)
// cfg     | in  | cfg_we                | cfg_index, cfg_wdata
//
// A report is handled in the back's idle state, as is a seek at time 0 or with no length
// known; any other seek reads the asked slot, then walks down and up from it (or down from
// the extent when past it), with a read, a wait and a check state per slot through the one
// RAM read port, then a 33-step serial divide if it interpolates, and any wait on out_ready
// follows. A length query walks down from the extent and may divide twice. After reset the
// table is cleared one slot a cycle; meanwhile only the 2-entry command queue takes input.
module seek_index_interpolator #(
  parameter int SLOTS    = sii_pkg::SLOTS_DEF,
  parameter int POS_BITS = sii_pkg::POS_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  sii_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output sii_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [31:0]        cfg_wdata
);
  logic [31:0] file_length;
  logic        length_known;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      file_length <= '0; length_known <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sii_pkg::CFG_FILE_LENGTH:  file_length  <= cfg_wdata;
        sii_pkg::CFG_LENGTH_KNOWN: length_known <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  sii_pkg::cmd_t  q_in, q_out;
  logic q_full;
  logic q_push, q_pop, q_ne;

  sii_front u_front (
    .in_valid, .in_ready, .in_data,
    .q_full, .q_push, .q_cmd(q_in)
  );

  sii_queue u_queue (
    .clk, .rst, .push(q_push), .wdata(q_in), .pop(q_pop),
    .not_empty(q_ne), .rdata(q_out), .full(q_full)
  );

  sii_back #(.SLOTS(SLOTS), .POS_BITS(POS_BITS)) u_back (
    .clk, .rst, .cmd_valid(q_ne), .cmd(q_out), .cmd_pop(q_pop),
    .file_length, .length_known, .out_valid, .out_ready, .out_data
  );
endmodule

// File: test/tb_seek_index_interpolator.sv
module tb_seek_index_interpolator;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSLOT     = 4096;
  localparam int WDOG_MAX  = 40 * NSLOT + 20000;
  localparam int DRAIN_CYC = 4 * NSLOT;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  sii_pkg::in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  sii_pkg::out_item_t out_data;
  logic      cfg_we = 1'b0;
  logic      cfg_index = sii_pkg::CFG_FILE_LENGTH;
  logic [31:0] cfg_wdata = '0;

  seek_index_interpolator i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 0;
  end

  // Shadow copy of the block's state, updated as each transfer is accepted.
  logic [31:0] idx_table [NSLOT];
  int unsigned idx_extent;
  bit          idx_rel;
  int unsigned idx_last;
  logic [31:0] flen;
  bit          flen_known;

  sii_pkg::in_item_t  pending_reqs[$];
  sii_pkg::out_item_t expected_answers[$];
  int  n_fail = 0;
  int  n_seen = 0;
  int  n_seek = 0, n_len = 0, n_fault = 0;
  bit  calm = 1'b0;      // no idling on either side while set
  bit  stim_done = 1'b0;
  int  wdog = 0;

  function automatic logic [31:0] sat32(logic [63:0] v);
    return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  // Highest nonzero slot above 0 below the extent; returns index, value via output arg.
  function automatic int unsigned top_known(output logic [63:0] val);
    val = 0;
    if (idx_extent == 0) return 0;
    for (int unsigned i = idx_extent - 1; i > 0; i--)
      if (idx_table[i] != 0) begin
        val = idx_table[i];
        return i;
      end
    return 0;
  endfunction

  function automatic logic [63:0] interp_offset(int unsigned t, output bit flt);
    logic [63:0] lo_t, lo_f, hi_t, hi_f, avg;
    int unsigned h;
    lo_t = 0; lo_f = 0; hi_t = 0; hi_f = 0;
    flt = 1'b0;
    if (t < idx_extent) begin
      lo_t = t;
      while (lo_t > 0 && idx_table[lo_t] == 0) lo_t--;
      lo_f = (lo_t > 0) ? idx_table[lo_t] : 0;
      h = t + 1;
      while (h < idx_extent && idx_table[h] == 0) h++;
      if (h < idx_extent) begin
        hi_t = h;
        hi_f = idx_table[h];
      end
    end else begin
      hi_t = top_known(hi_f);
    end
    if (hi_t > lo_t) begin
      if (hi_f < lo_f) begin
        flt = 1'b1;
        return 0;
      end
      avg = (hi_f - lo_f) / (hi_t - lo_t);
      if (t < hi_t) return sat32(lo_f + (t - lo_t) * avg);
      return sat32(hi_f + (t - hi_t) * avg);
    end
    return sat32(hi_f + 64'(sii_pkg::DEFAULT_RATE) * (t - hi_t));
  endfunction

  // Applies one accepted request to the shadow state; queues its answer, if it has one.
  task automatic predict_request(sii_pkg::in_item_t it);
    sii_pkg::out_item_t r;
    int unsigned t;
    logic [63:0] hf, avg, len, est;
    int unsigned ht;
    bit          flt;
    t = it.time_sec;
    r = '0;
    flt = 1'b0;
    case (it.req_type)
      sii_pkg::REQ_REPORT: begin
        if (idx_rel) begin
          if (t != idx_last && t < NSLOT && t < sii_pkg::YEAR_SECS) begin
            if (t >= idx_extent) idx_extent = (t == 0) ? 8 : ((2 * t > NSLOT) ? NSLOT : 2 * t);
            idx_table[t] = it.byte_pos;
          end
          idx_last = t;
        end
        return;
      end
      sii_pkg::REQ_SEEK: begin
        n_seek++;
        if (flen_known) begin
          r.seek_accepted = 1'b1;
          if (t == 0) r.reliable = 1'b1;
          else begin
            r.byte_offset = (t < idx_extent) ? idx_table[t] : 0;
            r.reliable = (r.byte_offset != 0);
            if (!r.reliable) begin
              est = interp_offset(t, flt);
              r.byte_offset = est[31:0];
            end
          end
          idx_rel = r.reliable;
          idx_last = t;
          r.arith_fault = flt;
        end
      end
      sii_pkg::REQ_LENGTH: begin
        n_len++;
        ht = top_known(hf);
        if (hf > 0) begin
          avg = hf / ht;
          if (avg == 0 || {32'd0, flen} < hf) flt = 1'b1;
          else begin
            len = ht + ({32'd0, flen} - hf) / avg;
            r.length_secs = sat32(len);
          end
        end else r.length_secs = flen / sii_pkg::DEFAULT_RATE;
        r.arith_fault = flt;
      end
      default: return;
    endcase
    if (r.arith_fault) n_fault++;
    expected_answers.push_back(r);
  endtask

  // Driver: one transfer at a time from the pending queue, random idle gaps unless calm.
  always @(posedge clk) begin
    if (rst) in_valid <= 1'b0;
    else if (in_valid && in_ready) begin
      predict_request(in_data);
      if (pending_reqs.size() > 0 && (calm || $urandom_range(99) >= 16)) begin
        in_data  <= pending_reqs.pop_front();
        in_valid <= 1'b1;
      end else in_valid <= 1'b0;
    end else if (!in_valid && pending_reqs.size() > 0 && (calm || $urandom_range(99) >= 16)) begin
      in_data  <= pending_reqs.pop_front();
      in_valid <= 1'b1;
    end
  end

  // Monitor: check each result transfer against the oldest expectation.
  always @(posedge clk) begin
    sii_pkg::out_item_t e;
    if (rst) out_ready <= 1'b0;
    else begin
      out_ready <= calm || ($urandom_range(99) >= 16);
      if (out_valid && out_ready) begin
        n_seen++;
        if (expected_answers.size() == 0) begin
          $error("unexpected result transfer: %p", out_data);
          n_fail++;
        end else begin
          e = expected_answers.pop_front();
          if (out_data.byte_offset !== e.byte_offset) begin
            $error("byte_offset exp %0d got %0d", e.byte_offset, out_data.byte_offset);
            n_fail++;
          end
          if (out_data.reliable !== e.reliable) begin
            $error("reliable exp %0d got %0d", e.reliable, out_data.reliable);
            n_fail++;
          end
          if (out_data.seek_accepted !== e.seek_accepted) begin
            $error("seek_accepted exp %0d got %0d", e.seek_accepted, out_data.seek_accepted);
            n_fail++;
          end
          if (out_data.length_secs !== e.length_secs) begin
            $error("length_secs exp %0d got %0d", e.length_secs, out_data.length_secs);
            n_fail++;
          end
          if (out_data.arith_fault !== e.arith_fault) begin
            $error("arith_fault exp %0d got %0d", e.arith_fault, out_data.arith_fault);
            n_fail++;
          end
        end
      end
    end
  end

  // Watchdog: cycles with no transfer on either channel. Reset clear pass
  // (one slot a cycle) and the longest seek walk both fit well inside.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || stim_done) wdog <= 0;
    else if (in_valid || expected_answers.size() > 0) begin
      wdog <= wdog + 1;
      if (wdog >= WDOG_MAX) begin
        $display("timeout, no transfer for %0d cycles", wdog);
        $display("tb_seek_index_interpolator NOT OK");
        $finish;
      end
    end
  end

  function automatic sii_pkg::in_item_t mk(logic [1:0] rq, logic [23:0] t, logic [31:0] p);
    sii_pkg::in_item_t it;
    it.req_type = rq;
    it.time_sec = t;
    it.byte_pos = p;
    return it;
  endfunction

  task automatic wait_idle();
    int n;
    n = 0;
    while ((pending_reqs.size() > 0 || in_valid || expected_answers.size() > 0) && n < 50 * WDOG_MAX) begin
      @(posedge clk);
      n++;
    end
    // reports give no result; let the last one settle
    repeat (64) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [31:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == sii_pkg::CFG_FILE_LENGTH) flen = val;
    else flen_known = val[0];
  endtask

  // Playback: rising offsets at a random rate, mixed at random with queries and noise.
  task automatic queue_playback(int n);
    logic [31:0] p;
    int unsigned t, rate;
    t = $urandom_range(1, 40);
    rate = $urandom_range(1, 60000);
    p = $urandom_range(1, 100000);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(9))
        0, 1: pending_reqs.push_back(mk(sii_pkg::REQ_SEEK,
                                        24'($urandom_range(0, 3 * t + 20)), 32'd0));
        2: pending_reqs.push_back(mk(sii_pkg::REQ_LENGTH, 24'($urandom), $urandom));
        3: pending_reqs.push_back(mk(2'($urandom_range(3)), 24'($urandom), $urandom)); // noise
        default: begin
          pending_reqs.push_back(mk(sii_pkg::REQ_REPORT, 24'(t), p));
          t += $urandom_range(1, 3);
          p += rate * $urandom_range(1, 3);
        end
      endcase
    end
  endtask

  initial begin
    for (int i = 0; i < NSLOT; i++) idx_table[i] = 0;
    idx_extent = 0; idx_rel = 1'b1; idx_last = 0;
    flen = 0; flen_known = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: refused seek, length with empty table, reports incl. repeat,
    // second zero, decreasing entries, unused code, field extremes.
    pending_reqs.push_back(mk(sii_pkg::REQ_SEEK, 24'd5, 32'hFFFF_FFFF));
    pending_reqs.push_back(mk(sii_pkg::REQ_LENGTH, 24'hFFFFFF, 32'hFFFF_FFFF));
    pending_reqs.push_back(mk(sii_pkg::REQ_REPORT, 24'd0, 32'hFFFF_FFFF));
    pending_reqs.push_back(mk(sii_pkg::REQ_REPORT, 24'd1, 32'd1000));
    pending_reqs.push_back(mk(sii_pkg::REQ_REPORT, 24'd1, 32'd9999));
    pending_reqs.push_back(mk(sii_pkg::REQ_REPORT, 24'd4, 32'd50000));
    pending_reqs.push_back(mk(sii_pkg::REQ_NONE, 24'hFFFFFF, 32'hFFFF_FFFF));
    pending_reqs.push_back(mk(sii_pkg::REQ_REPORT, 24'hFFFFFF, 32'd7));
    pending_reqs.push_back(mk(sii_pkg::REQ_REPORT, 24'd4095, 32'd60000));
    pending_reqs.push_back(mk(sii_pkg::REQ_LENGTH, 24'd0, 32'd0));
    wait_idle();
    write_reg(sii_pkg::CFG_FILE_LENGTH, 32'hFFFF_FFFF);
    write_reg(sii_pkg::CFG_LENGTH_KNOWN, 1'b1);
    pending_reqs.push_back(mk(sii_pkg::REQ_LENGTH, 24'd0, 32'd0));
    pending_reqs.push_back(mk(sii_pkg::REQ_SEEK, 24'd0, 32'd0));
    pending_reqs.push_back(mk(sii_pkg::REQ_SEEK, 24'd1, 32'd0));
    pending_reqs.push_back(mk(sii_pkg::REQ_SEEK, 24'd3, 32'd0));
    pending_reqs.push_back(mk(sii_pkg::REQ_SEEK, 24'd5000, 32'd0));
    pending_reqs.push_back(mk(sii_pkg::REQ_SEEK, 24'hFFFFFF, 32'd0));
    pending_reqs.push_back(mk(sii_pkg::REQ_SEEK, 24'd4, 32'd0));
    pending_reqs.push_back(mk(sii_pkg::REQ_REPORT, 24'd2, 32'd90000)); // decreasing entry
    pending_reqs.push_back(mk(sii_pkg::REQ_SEEK, 24'd3, 32'd0));   // flags the fault
    pending_reqs.push_back(mk(sii_pkg::REQ_REPORT, 24'd6, 32'd1)); // ignored, not reliable
    pending_reqs.push_back(mk(sii_pkg::REQ_SEEK, 24'd0, 32'd0));
    wait_idle();
    write_reg(sii_pkg::CFG_FILE_LENGTH, 32'd0);
    pending_reqs.push_back(mk(sii_pkg::REQ_LENGTH, 24'd0, 32'd0));
    wait_idle();

    // Random phases with varied register settings; the fourth one runs calm.
    for (int ph = 0; ph < 6; ph++) begin
      calm = (ph == 3);
      write_reg(sii_pkg::CFG_FILE_LENGTH, (ph == 2) ? 32'hFFFF_FFFF : $urandom);
      write_reg(sii_pkg::CFG_LENGTH_KNOWN, (ph != 4));
      pending_reqs.push_back(mk(sii_pkg::REQ_SEEK, 24'd0, 32'd0)); // restore reliable when length is known
      queue_playback(19);
      wait_idle();
    end
    calm = 1'b0;
    repeat (DRAIN_CYC) @(posedge clk);
    stim_done = 1'b1;

    $display("covered %0d seeks and %0d length queries, %0d with an arithmetic fault",
             n_seek, n_len, n_fault);
    if (n_fail == 0 && expected_answers.size() == 0)
      $display("tb_seek_index_interpolator OK");
    else begin
      if (expected_answers.size() != 0) $error("%0d results never arrived", expected_answers.size());
      $display("tb_seek_index_interpolator NOT OK");
    end
    $finish;
  end

endmodule
